// ----- rtl/core/slt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sorted list table.
// No dependencies; every other file in the block uses this package.
package slt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int USED_W   = $clog2(CAPACITY + 1);

  localparam int OP_W    = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE      = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH_HEAD = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH_TAIL = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT       = 3'd4;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

endpackage

// ----- rtl/core/slt_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels carrying operation items and result items.
// Depends on slt_pkg for field widths.
interface slt_req_if;
  logic                                valid;
  logic                                ready;
  logic [slt_pkg::OP_W-1:0]            op;
  logic signed [slt_pkg::VAL_W-1:0]    value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface slt_res_if;
  logic                                valid;
  logic                                ready;
  logic                                success;
  logic [slt_pkg::POS_W-1:0]           position;
  logic [slt_pkg::COUNT_W-1:0]         entry_count;

  modport source (output valid, output success, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input success, input position, input entry_count,
                  output ready);
endinterface

// ----- rtl/core/slt_cell.sv -----
`timescale 1ns / 1ps
// One cell of the table: holds one entry, compares it against the key and
// shifts with its neighbours on insert and delete. Depends on slt_pkg.
module slt_cell (
  input  logic                              clk_i,
  input  slt_pkg::cell_ctl_t                ctl_i,
  input  logic signed [slt_pkg::VAL_W-1:0]  key_i,
  input  logic signed [slt_pkg::VAL_W-1:0]  ins_value_i,
  input  logic                              valid_i,
  input  logic                              prev_ge_i,
  input  logic signed [slt_pkg::VAL_W-1:0]  prev_entry_i,
  input  logic signed [slt_pkg::VAL_W-1:0]  next_entry_i,
  output logic                              ge_o,
  output logic                              hit_o,
  output logic signed [slt_pkg::VAL_W-1:0]  entry_o
);

  logic signed [slt_pkg::VAL_W-1:0] entry_q;
  logic                             ge_d, ge_q;
  logic                             eq_d, eq_q;

  assign ge_d = !valid_i || (entry_q >= key_i);
  assign eq_d = valid_i && (entry_q == key_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp_en) begin
      ge_q <= ge_d;
      eq_q <= eq_d;
    end
    if (ctl_i.ins_en && ge_q) begin
      entry_q <= prev_ge_i ? prev_entry_i : ins_value_i;
    end else if (ctl_i.del_en && ge_q) begin
      entry_q <= next_entry_i;
    end
  end

  assign ge_o    = ge_q;
  assign hit_o   = ge_q && !prev_ge_i && eq_q;
  assign entry_o = entry_q;

endmodule

// ----- rtl/core/sorted_list_table_unit.sv -----
`timescale 1ns / 1ps
// Sorted list table: a chain of cells keeping signed 32-bit values in
// ascending order. Every cell compares its entry with the operand in the
// cycle the item is accepted; when the output register is free, the cells
// from the first one not below the operand shift together for insert or
// delete while the result is registered. An item thus passes the compare
// step and then the shift step of the cell chain; a new item is taken once
// the previous one has moved to the output register, which holds its result
// until the sink takes it. Reset empties the table at once; no clearing
// pass is needed. Depends on slt_pkg, slt_if and slt_cell.
module sorted_list_table_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  slt_req_if.sink       req_i,
  slt_res_if.source     res_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXE  = 1'b1;

  logic                              state_q, state_d;
  logic [slt_pkg::OP_W-1:0]          op_q;
  logic signed [slt_pkg::VAL_W-1:0]  value_q;
  logic [slt_pkg::USED_W-1:0]        used_q, used_d;

  logic                              res_valid_q;
  logic                              res_success_q, res_success_d;
  logic [slt_pkg::POS_W-1:0]         res_position_q, res_position_d;
  logic [slt_pkg::COUNT_W-1:0]       res_count_q;

  logic                              accept;
  logic                              exe_fire;
  logic                              hit;
  logic                              room;
  logic [slt_pkg::IDX_W-1:0]         hit_idx;
  logic [slt_pkg::CAPACITY-1:0]      ge_vec;
  logic [slt_pkg::CAPACITY-1:0]      hit_vec;
  logic signed [slt_pkg::VAL_W-1:0]  entry_w [slt_pkg::CAPACITY];
  slt_pkg::cell_ctl_t                ctl;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign exe_fire    = (state_q == ST_EXE) && (!res_valid_q || res_o.ready);

  assign hit  = |hit_vec;
  assign room = (used_q < slt_pkg::USED_W'(slt_pkg::CAPACITY));

  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < slt_pkg::CAPACITY; k++) begin
      if (hit_vec[k]) begin
        hit_idx = hit_idx | slt_pkg::IDX_W'(k);
      end
    end
  end

  assign ctl.cmp_en = accept;
  assign ctl.ins_en = exe_fire && (op_q == slt_pkg::OP_INSERT) && room;
  assign ctl.del_en = exe_fire && (op_q == slt_pkg::OP_DELETE) && hit;

  for (genvar i = 0; i < slt_pkg::CAPACITY; i++) begin : g_cell
    logic                             prev_ge;
    logic signed [slt_pkg::VAL_W-1:0] prev_entry;
    logic signed [slt_pkg::VAL_W-1:0] next_entry;

    if (i == 0) begin : g_head
      assign prev_ge    = 1'b0;
      assign prev_entry = entry_w[0];
    end else begin : g_body
      assign prev_ge    = ge_vec[i-1];
      assign prev_entry = entry_w[i-1];
    end
    if (i == slt_pkg::CAPACITY - 1) begin : g_tail
      assign next_entry = entry_w[i];
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
    end

    slt_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .key_i        (req_i.value),
      .ins_value_i  (value_q),
      .valid_i      (slt_pkg::USED_W'(i) < used_q),
      .prev_ge_i    (prev_ge),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .ge_o         (ge_vec[i]),
      .hit_o        (hit_vec[i]),
      .entry_o      (entry_w[i])
    );
  end

  always_comb begin
    used_d         = used_q;
    res_success_d  = 1'b0;
    res_position_d = '0;
    case (op_q)
      slt_pkg::OP_INSERT: begin
        if (room) begin
          used_d        = used_q + 1'b1;
          res_success_d = 1'b1;
        end
      end
      slt_pkg::OP_DELETE: begin
        if (hit) begin
          used_d        = used_q - 1'b1;
          res_success_d = 1'b1;
        end
      end
      slt_pkg::OP_SEARCH_HEAD: begin
        if (hit) begin
          res_success_d  = 1'b1;
          res_position_d = slt_pkg::POS_W'(hit_idx);
        end
      end
      slt_pkg::OP_SEARCH_TAIL: begin
        if (hit) begin
          res_success_d  = 1'b1;
          res_position_d = slt_pkg::POS_W'(used_q - slt_pkg::USED_W'(hit_idx) - 1'b1);
        end
      end
      slt_pkg::OP_COUNT: begin
        res_success_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept)   state_d = ST_EXE;
      ST_EXE:  if (exe_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exe_fire) begin
        used_q      <= used_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req_i.op;
      value_q <= req_i.value;
    end
    if (exe_fire) begin
      res_success_q  <= res_success_d;
      res_position_q <= res_position_d;
      res_count_q    <= slt_pkg::COUNT_W'(used_d);
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.success     = res_success_q;
  assign res_o.position    = res_position_q;
  assign res_o.entry_count = res_count_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= slt_pkg::USED_W'(slt_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_hit_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXE) |-> $onehot0(hit_vec))
    else $error("more than one cell reports the first match");

  a_accept_exe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXE))
    else $error("accepted item did not enter execute");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exe_fire |=> (res_valid_q && (res_count_q == slt_pkg::COUNT_W'(used_q))))
    else $error("result not presented with updated count");

  a_insert_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ins_en |=> (used_q == $past(used_q) + 1'b1))
    else $error("insert did not grow the table");

endmodule
